[src/tifr_pkg.sv]
// Package for the timestamp indexed frame ring.
// Holds the command codes and the fixed field widths of the stream ports.
// No dependencies.
package tifr_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    localparam int STAMP_W      = 64;
    localparam int PAY_FIELD_W  = 32;
    localparam int SLOT_FIELD_W = 6;
    localparam int CNT_FIELD_W  = 7;
    localparam int S_TDATA_W    = 96;
    localparam int M_TDATA_W    = 112;

endpackage

[src/tifr_slot_ram.sv]
// Slot memory of the frame ring: one write port and one read port.
// Read data is registered. No dependencies.
module tifr_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 97
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/timestamp_indexed_frame_ring.sv]
// Top level of the timestamp indexed frame ring: sequencer, state registers
// and output register. Depends on tifr_pkg and tifr_slot_ram.
//
// Channel   Dir  Ports                          Contents
// s_        in   s_tvalid s_tready s_tdata s_tuser  command, stamp, payload
// m_        out  m_tvalid m_tready m_tdata m_tuser  ok, slot, stamp, payload, count
// cfg_      in   cfg_wr_en cfg_wr_data          enable register
//
// A push reads the old slot, makes a read-modify-write sweep of the slot memory,
// then does the final write and the load of the result register. A lookup first
// reads the last hit slot when it is valid and answers from it when it matches;
// otherwise it sweeps the memory. A clear writes every slot once; the clearing
// pass after reset also writes every slot once.
// No transaction is accepted while the block is busy or a result is not yet
// stored; a stalled result register holds the next one in its final state.
module timestamp_indexed_frame_ring #(
    parameter int SLOTS        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // stamp [63:0], payload [95:64]
    input  logic [tifr_pkg::S_TDATA_W-1:0] s_tdata,
    // command [1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot [5:0], found_stamp [69:6], found_payload [101:70],
    // valid_count [108:102], zero [111:109]
    output logic [tifr_pkg::M_TDATA_W-1:0] m_tdata,
    // ok [0]
    output logic                           m_tuser,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PW = (PAYLOAD_BITS < tifr_pkg::PAY_FIELD_W) ? PAYLOAD_BITS
                                                                : tifr_pkg::PAY_FIELD_W;
    localparam int SW = tifr_pkg::STAMP_W;
    localparam int EW = 1 + SW + PW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PUSH_RD,
        ST_PUSH_OLD,
        ST_PUSH_SWEEP,
        ST_PUSH_WR,
        ST_LK_RD,
        ST_LK_CACHE,
        ST_LK_SWEEP,
        ST_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pend_addr_reg, pend_addr_next;
    logic            clr_cmd_reg, clr_cmd_next;
    logic [SW-1:0]   stamp_reg, stamp_next;
    logic [SW-1:0]   stamp_inc_reg, stamp_inc_next;
    logic [PW-1:0]   payload_reg, payload_next;
    logic [SW-1:0]   old_stamp_reg, old_stamp_next;
    logic            clr_old_reg, clr_old_next;
    logic            now_valid_reg, now_valid_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   lh_slot_reg, lh_slot_next;
    logic            lh_valid_reg, lh_valid_next;
    logic            enable_reg, enable_next;
    logic            res_ok_reg, res_ok_next;
    logic [AW-1:0]   res_slot_reg, res_slot_next;
    logic [SW-1:0]   res_stamp_reg, res_stamp_next;
    logic [PW-1:0]   res_pay_reg, res_pay_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [tifr_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic            m_tuser_reg, m_tuser_next;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [EW-1:0]   rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;
    logic            rd_mapped;
    logic [SW-1:0]   rd_stamp;
    logic [PW-1:0]   rd_pay;
    logic            old_pos;
    logic            new_pos;
    logic            sweep_done;

    tifr_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (AW),
        .W     (EW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_mapped  = rd_data[EW-1];
    assign rd_stamp   = rd_data[PW +: SW];
    assign rd_pay     = rd_data[PW-1:0];
    assign old_pos    = (rd_stamp != '0) && !rd_stamp[SW-1];
    assign new_pos    = (stamp_reg != '0) && !stamp_reg[SW-1];
    assign sweep_done = (idx_reg == CW'(SLOTS)) && !pend_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        clr_cmd_next   = clr_cmd_reg;
        stamp_next     = stamp_reg;
        stamp_inc_next = stamp_inc_reg;
        payload_next   = payload_reg;
        old_stamp_next = old_stamp_reg;
        clr_old_next   = clr_old_reg;
        now_valid_next = now_valid_reg;
        wp_next        = wp_reg;
        count_next     = count_reg;
        lh_slot_next   = lh_slot_reg;
        lh_valid_next  = lh_valid_reg;
        enable_next    = enable_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        res_stamp_next = res_stamp_reg;
        res_pay_next   = res_pay_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_data        = '0;

        if (cfg_wr_en) begin
            enable_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    stamp_next     = s_tdata[SW-1:0];
                    stamp_inc_next = s_tdata[SW-1:0] + SW'(1);
                    payload_next   = s_tdata[SW +: PW];
                    res_ok_next    = 1'b0;
                    res_slot_next  = '0;
                    res_stamp_next = '0;
                    res_pay_next   = '0;
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    unique case (s_tuser)
                        tifr_pkg::CMD_CLEAR: begin
                            clr_cmd_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        tifr_pkg::CMD_PUSH: begin
                            state_next = enable_reg ? ST_PUSH_RD : ST_FINISH;
                        end
                        tifr_pkg::CMD_LOOKUP: begin
                            if (!enable_reg) begin
                                state_next = ST_FINISH;
                            end else if (lh_valid_reg) begin
                                state_next = ST_LK_RD;
                            end else begin
                                state_next = ST_LK_SWEEP;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                wr_en    = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(SLOTS - 1)) begin
                    wp_next       = '0;
                    count_next    = '0;
                    lh_slot_next  = '0;
                    lh_valid_next = 1'b0;
                    res_ok_next   = 1'b1;
                    state_next    = clr_cmd_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_PUSH_RD: begin
                rd_en      = 1'b1;
                rd_addr    = wp_reg;
                state_next = ST_PUSH_OLD;
            end
            ST_PUSH_OLD: begin
                old_stamp_next = rd_stamp;
                clr_old_next   = old_pos && (rd_stamp != stamp_reg);
                now_valid_next = new_pos;
                if (!old_pos && new_pos && (count_reg != CW'(SLOTS))) begin
                    count_next = count_reg + CW'(1);
                end else if (old_pos && !new_pos && (count_reg != '0)) begin
                    count_next = count_reg - CW'(1);
                end
                state_next = ST_PUSH_SWEEP;
            end
            ST_PUSH_SWEEP: begin
                pend_next = 1'b0;
                if (idx_reg != CW'(SLOTS)) begin
                    rd_en          = 1'b1;
                    idx_next       = idx_reg + CW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                end
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg;
                    wr_data = {rd_mapped
                               && !(clr_old_reg && (rd_stamp == old_stamp_reg))
                               && !(now_valid_reg && (rd_stamp == stamp_reg)),
                               rd_stamp, rd_pay};
                end
                if (sweep_done) begin
                    state_next = ST_PUSH_WR;
                end
            end
            ST_PUSH_WR: begin
                wr_en          = 1'b1;
                wr_addr        = wp_reg;
                wr_data        = {now_valid_reg, stamp_reg, payload_reg};
                res_ok_next    = 1'b1;
                res_slot_next  = wp_reg;
                res_stamp_next = stamp_reg;
                res_pay_next   = payload_reg;
                wp_next        = (wp_reg == AW'(SLOTS - 1)) ? '0 : wp_reg + AW'(1);
                state_next     = ST_FINISH;
            end
            ST_LK_RD: begin
                rd_en      = 1'b1;
                rd_addr    = lh_slot_reg;
                state_next = ST_LK_CACHE;
            end
            ST_LK_CACHE: begin
                if ((rd_stamp == stamp_reg) || (rd_stamp == stamp_inc_reg)) begin
                    res_ok_next    = 1'b1;
                    res_slot_next  = lh_slot_reg;
                    res_stamp_next = rd_stamp;
                    res_pay_next   = rd_pay;
                    state_next     = ST_FINISH;
                end else begin
                    state_next = ST_LK_SWEEP;
                end
            end
            ST_LK_SWEEP: begin
                pend_next = 1'b0;
                if (idx_reg != CW'(SLOTS)) begin
                    rd_en          = 1'b1;
                    idx_next       = idx_reg + CW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                end
                if (pend_reg && rd_mapped && (rd_stamp == stamp_reg)) begin
                    res_ok_next    = 1'b1;
                    res_slot_next  = pend_addr_reg;
                    res_stamp_next = rd_stamp;
                    res_pay_next   = rd_pay;
                    lh_slot_next   = pend_addr_reg;
                    lh_valid_next  = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = ST_FINISH;
                end else if (sweep_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_ok_reg;
                    m_tdata_next  = {3'b000,
                                     tifr_pkg::CNT_FIELD_W'(count_reg),
                                     tifr_pkg::PAY_FIELD_W'(res_pay_reg),
                                     res_stamp_reg,
                                     tifr_pkg::SLOT_FIELD_W'(res_slot_reg)};
                    clr_cmd_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            clr_cmd_reg   <= 1'b0;
            wp_reg        <= '0;
            count_reg     <= '0;
            lh_slot_reg   <= '0;
            lh_valid_reg  <= 1'b0;
            enable_reg    <= 1'b1;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            clr_cmd_reg   <= clr_cmd_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            lh_slot_reg   <= lh_slot_next;
            lh_valid_reg  <= lh_valid_next;
            enable_reg    <= enable_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        pend_addr_reg <= pend_addr_next;
        stamp_reg     <= stamp_next;
        stamp_inc_reg <= stamp_inc_next;
        payload_reg   <= payload_next;
        old_stamp_reg <= old_stamp_next;
        clr_old_reg   <= clr_old_next;
        now_valid_reg <= now_valid_next;
        res_ok_reg    <= res_ok_next;
        res_slot_reg  <= res_slot_next;
        res_stamp_reg <= res_stamp_next;
        res_pay_reg   <= res_pay_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(SLOTS))
        else $error("Valid slot count exceeds the number of slots.");

    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready) |=> m_tvalid_reg)
        else $error("Finished transaction did not reach the output register.");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_reg)
        else $error("Memory read still pending while accepting a transaction.");

    a_lookup_keeps_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LK_SWEEP) |=> $stable(wp_reg) && $stable(count_reg))
        else $error("Lookup sweep changed the write pointer or the count.");
`endif

endmodule

[tb/timestamp_indexed_frame_ring_test.sv]
// Self-checking testbench for the timestamp indexed frame ring: directed and random push,
// lookup and clear transactions, with every result checked against a model of the ring.
// Depends on tifr_pkg and the timestamp_indexed_frame_ring RTL.

typedef struct {
    logic        ok;
    logic [5:0]  slot;
    logic [63:0] stamp;
    logic [31:0] payload;
    logic [6:0]  count;
} ring_answer_t;

class frame_ring_tracker;
    localparam int SLOTS = 64;

    logic [63:0]  stamps[SLOTS];
    logic [31:0]  payloads[SLOTS];
    bit           marked[SLOTS];
    int           write_slot;
    int           valid_total;
    int           hit_slot;
    bit           hit_valid;
    bit           enabled;
    int           faults;
    ring_answer_t awaited[$];

    function new();
        enabled = 1'b1;
        faults = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (stamps[i]) begin
            stamps[i] = '0;
            payloads[i] = '0;
            marked[i] = 1'b0;
        end
        write_slot = 0;
        valid_total = 0;
        hit_slot = 0;
        hit_valid = 1'b0;
    endfunction

    function bit positive(logic [63:0] s);
        return s != 64'd0 && !s[63];
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function ring_answer_t answer(logic ok, int slot, logic [63:0] stamp, logic [31:0] payload);
        ring_answer_t a;
        a.ok = ok;
        a.slot = slot[5:0];
        a.stamp = stamp;
        a.payload = payload;
        a.count = valid_total[6:0];
        return a;
    endfunction

    function ring_answer_t predict_push(logic [63:0] stamp, logic [31:0] payload);
        int          wp;
        logic [63:0] old;
        bit          was_valid;
        bit          now_valid;
        wp = write_slot;
        old = stamps[wp];
        was_valid = positive(old);
        now_valid = positive(stamp);
        if (was_valid && old != stamp) begin
            foreach (stamps[i])
                if (stamps[i] == old) marked[i] = 1'b0;
        end
        stamps[wp] = stamp;
        payloads[wp] = payload;
        if (!was_valid && now_valid) begin
            if (valid_total < SLOTS) valid_total++;
        end else if (was_valid && !now_valid) begin
            if (valid_total > 0) valid_total--;
        end
        if (now_valid) begin
            foreach (stamps[i])
                if (stamps[i] == stamp) marked[i] = 1'b0;
            marked[wp] = 1'b1;
        end
        write_slot = (wp + 1 >= SLOTS) ? 0 : wp + 1;
        return answer(1'b1, wp, stamp, payload);
    endfunction

    function ring_answer_t predict_lookup(logic [63:0] target);
        logic [63:0] held;
        if (hit_valid) begin
            held = stamps[hit_slot];
            if (held == target || held == target + 64'd1)
                return answer(1'b1, hit_slot, held, payloads[hit_slot]);
        end
        foreach (stamps[i]) begin
            if (marked[i] && stamps[i] == target) begin
                hit_slot = i;
                hit_valid = 1'b1;
                return answer(1'b1, i, stamps[i], payloads[i]);
            end
        end
        return answer(1'b0, 0, '0, '0);
    endfunction

    function void note_command(logic [1:0] cmd, logic [63:0] stamp, logic [31:0] payload);
        ring_answer_t a;
        case (cmd)
            tifr_pkg::CMD_CLEAR: begin
                wipe();
                a = answer(1'b1, 0, '0, '0);
            end
            tifr_pkg::CMD_PUSH:
                a = enabled ? predict_push(stamp, payload) : answer(1'b0, 0, '0, '0);
            tifr_pkg::CMD_LOOKUP:
                a = enabled ? predict_lookup(stamp) : answer(1'b0, 0, '0, '0);
            default: a = answer(1'b0, 0, '0, '0);
        endcase
        awaited.push_back(a);
    endfunction

    function void check_answer(logic ok, logic [tifr_pkg::M_TDATA_W-1:0] data);
        ring_answer_t e;
        ring_answer_t got;
        got.ok = ok;
        got.slot = data[5:0];
        got.stamp = data[69:6];
        got.payload = data[101:70];
        got.count = data[108:102];
        if (awaited.size() == 0) begin
            faults++;
            if (faults <= 10)
                $display("Unexpected result: ok %b slot %0d stamp %h payload %h count %0d",
                         got.ok, got.slot, got.stamp, got.payload, got.count);
            return;
        end
        e = awaited.pop_front();
        if (got.ok !== e.ok || got.slot !== e.slot || got.stamp !== e.stamp
                || got.payload !== e.payload || got.count !== e.count) begin
            faults++;
            if (faults <= 10) begin
                $display("Mismatch, expected: ok %b slot %0d stamp %h payload %h count %0d",
                         e.ok, e.slot, e.stamp, e.payload, e.count);
                $display("          actual:   ok %b slot %0d stamp %h payload %h count %0d",
                         got.ok, got.slot, got.stamp, got.payload, got.count);
            end
        end
    endfunction
endclass

module timestamp_indexed_frame_ring_test;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          PRESSURE_CYCLES = 600;
    localparam int          SETTLE_CYCLES = 80;
    localparam logic [63:0] STAMP_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] STAMP_MIN = 64'h8000_0000_0000_0000;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tifr_pkg::S_TDATA_W-1:0] s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [tifr_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           cfg_wr_en;
    logic                           cfg_wr_data;

    frame_ring_tracker book = new();
    bit                sender_quiet = 1'b0;
    bit                receiver_quiet = 1'b0;
    int                answers_seen = 0;

    always #5 aclk = ~aclk;

    timestamp_indexed_frame_ring #(
        .SLOTS       (64),
        .PAYLOAD_BITS(32)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    task automatic offer(input logic [1:0] cmd, input logic [63:0] stamp,
                         input logic [31:0] payload);
        int gap;
        if ($urandom_range(0, 29) == 0) sender_quiet = !sender_quiet;
        gap = sender_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {payload, stamp};
        do @(posedge aclk); while (!s_tready);
        book.note_command(cmd, stamp, payload);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_enable(input logic value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        book.enabled = value;
    endtask

    // Mostly small positive stamps so that duplicates, remapping and lookup hits are common.
    function automatic logic [63:0] pool_stamp();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 64'($urandom_range(1, 24));
        else if (r < 78) return 64'd0;
        else if (r < 86) return {$urandom, $urandom};
        else if (r < 92) return 64'd0 - 64'($urandom_range(1, 3));
        else if (r < 96) return STAMP_MAX - 64'($urandom_range(0, 2));
        return STAMP_MIN + 64'($urandom_range(0, 2));
    endfunction

    task automatic random_items(input int n);
        int unsigned r;
        logic [63:0] stamp;
        repeat (n) begin
            r = $urandom_range(0, 199);
            stamp = pool_stamp();
            if (r < 108)
                offer(tifr_pkg::CMD_PUSH, stamp, $urandom);
            else if (r < 190)
                offer(tifr_pkg::CMD_LOOKUP,
                      ($urandom_range(0, 3) == 0) ? stamp - 64'd1 : stamp, $urandom);
            else if (r < 199)
                offer(CMD_UNUSED, stamp, $urandom);
            else
                offer(tifr_pkg::CMD_CLEAR, stamp, $urandom);
        end
    endtask

    initial begin : stimulus
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= tifr_pkg::CMD_PUSH;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        set_enable(1'b1);

        offer(tifr_pkg::CMD_LOOKUP, 64'd5, 32'h0);
        offer(tifr_pkg::CMD_PUSH, 64'd1, 32'h0);
        offer(tifr_pkg::CMD_PUSH, STAMP_MAX, 32'hffff_ffff);
        offer(tifr_pkg::CMD_PUSH, 64'd0, 32'h1234_5678);
        offer(tifr_pkg::CMD_PUSH, STAMP_MIN, 32'ha5a5_a5a5);
        offer(tifr_pkg::CMD_PUSH, 64'hffff_ffff_ffff_ffff, 32'h1);
        offer(tifr_pkg::CMD_PUSH, 64'd1, 32'h2);
        offer(tifr_pkg::CMD_LOOKUP, 64'd1, 32'h0);
        // The cached slot also answers a target one below its own stamp.
        offer(tifr_pkg::CMD_LOOKUP, 64'd0, 32'h0);
        offer(tifr_pkg::CMD_LOOKUP, STAMP_MAX, 32'h0);
        offer(tifr_pkg::CMD_LOOKUP, STAMP_MAX - 64'd1, 32'h0);
        offer(tifr_pkg::CMD_LOOKUP, STAMP_MIN, 32'h0);
        offer(tifr_pkg::CMD_LOOKUP, 64'd0, 32'h0);
        offer(tifr_pkg::CMD_PUSH, 64'd7, 32'h5a5a_5a5a);
        offer(tifr_pkg::CMD_PUSH, 64'd7, 32'h0f0f_0f0f);
        offer(tifr_pkg::CMD_LOOKUP, 64'd7, 32'h0);
        settle();

        set_enable(1'b0);
        offer(tifr_pkg::CMD_PUSH, 64'd9, 32'h1);
        offer(tifr_pkg::CMD_LOOKUP, 64'd7, 32'h0);
        offer(tifr_pkg::CMD_CLEAR, 64'd0, 32'h0);
        offer(CMD_UNUSED, 64'd7, 32'h0);
        random_items(40);
        settle();

        set_enable(1'b1);
        random_items(250);
        settle();
        set_enable(1'b0);
        random_items(25);
        settle();
        set_enable(1'b1);
        random_items(235);
        settle();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (book.faults == 0 && book.pending() == 0)
            $display("timestamp_indexed_frame_ring verification clean");
        else
            $display("timestamp_indexed_frame_ring verification failed");
        $finish;
    end

    initial begin : receiver
        int gap;
        m_tready <= 1'b0;
        forever begin
            if ($urandom_range(0, 29) == 0) receiver_quiet = !receiver_quiet;
            gap = receiver_quiet ? 0 : $urandom_range(0, 18);
            // One long hold-off so that the ring backs up and stops taking input.
            if (answers_seen == 200) gap = PRESSURE_CYCLES;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            book.check_answer(m_tuser, m_tdata);
            answers_seen++;
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("timestamp_indexed_frame_ring verification failed");
        $finish;
    end

endmodule
